// ===== rtl/kms_pkg.sv =====
// Keypad matrix scanner package: matrix size, phase encoding and the
// state and result records shared by the step logic and the top level.
`default_nettype none
package kms_pkg;

    localparam int unsigned ROWS      = 3;
    localparam int unsigned COLS      = 3;
    localparam int unsigned KEYS      = ROWS * COLS;
    localparam int unsigned LEVEL_W   = 3;
    localparam int unsigned IDX_W     = 2;
    localparam int unsigned KPOS_W    = $clog2(KEYS);
    localparam int unsigned HCNT_W    = $clog2(KEYS + 1);
    localparam int unsigned WAIT_W    = 8;
    localparam logic [WAIT_W-1:0] DEBOUNCE_RESET = 8'd2;
    localparam logic [IDX_W-1:0]  LAST_ROW = IDX_W'(ROWS - 1);
    localparam logic [IDX_W-1:0]  LAST_COL = IDX_W'(COLS - 1);

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_DEBOUNCE = 5'b00010,
        PH_COLUMN   = 5'b00100,
        PH_PROBE    = 5'b01000,
        PH_POLL     = 5'b10000
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [WAIT_W-1:0]   wait_count;
        logic [IDX_W-1:0]    column_index;
        logic [IDX_W-1:0]    row_index;
        logic [KEYS-1:0]     held_mask;
        logic [HCNT_W-1:0]   held_count;
    } scan_state_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]  row_drive;
        logic                event_valid;
        logic                event_release;
        logic [IDX_W-1:0]    key_row;
        logic [IDX_W-1:0]    key_column;
        logic                busy_res;
    } scan_result_t;

    localparam scan_state_t STATE_RESET = '{
        phase:        PH_IDLE,
        wait_count:   '0,
        column_index: '0,
        row_index:    '0,
        held_mask:    '0,
        held_count:   '0
    };

    function automatic logic [KPOS_W-1:0] key_pos(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
        key_pos = KPOS_W'({r, 1'b0}) + KPOS_W'(r) + KPOS_W'(c);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/kms_apb_regs.sv =====
// Keypad matrix scanner configuration register file on an APB-style port.
// Depends on kms_pkg for the debounce width and reset value.
`default_nettype none
module kms_apb_regs (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [2:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output logic      [kms_pkg::WAIT_W-1:0] debounce_ticks
);
    import kms_pkg::*;

    localparam logic ADDR_DEBOUNCE = 1'b0;

    logic [WAIT_W-1:0] debounce_reg;
    logic [WAIT_W-1:0] debounce_next;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_comb begin
        debounce_next = debounce_reg;
        if (wr_en && paddr[2] == ADDR_DEBOUNCE) begin
            debounce_next = pwdata[WAIT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
        end else begin
            debounce_reg <= debounce_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == ADDR_DEBOUNCE) begin
            prdata = {{(32-WAIT_W){1'b0}}, debounce_reg};
        end
    end

    assign debounce_ticks = debounce_reg;

endmodule
`default_nettype wire

// ===== rtl/kms_step.sv =====
// Keypad matrix scanner step logic: next scan state and result for one tick.
// Purely combinational; depends on kms_pkg.
`default_nettype none
module kms_step (
    input  wire kms_pkg::scan_state_t        cur,
    input  wire logic [kms_pkg::LEVEL_W-1:0] levels,
    input  wire logic [kms_pkg::WAIT_W-1:0]  debounce_ticks,
    output kms_pkg::scan_state_t          nxt,
    output kms_pkg::scan_result_t         res
);
    import kms_pkg::*;

    localparam logic [LEVEL_W-1:0] COLMASK = LEVEL_W'((1 << COLS) - 1);

    always_comb begin
        scan_state_t        s;
        scan_result_t       o;
        logic               col_high;
        logic [KPOS_W-1:0]  pos;

        s        = cur;
        o        = '0;
        col_high = levels[cur.column_index];
        pos      = key_pos(cur.row_index, cur.column_index);

        case (cur.phase)
            PH_IDLE: begin
                if ((levels & COLMASK) != COLMASK) begin
                    if (debounce_ticks == '0) begin
                        s = STATE_RESET;
                        s.phase = PH_COLUMN;
                    end else begin
                        s.wait_count = debounce_ticks;
                        s.phase      = PH_DEBOUNCE;
                    end
                end
            end
            PH_DEBOUNCE: begin
                if (cur.wait_count != '0) begin
                    s.wait_count = cur.wait_count - 1'b1;
                end
                if (s.wait_count == '0) begin
                    s = STATE_RESET;
                    s.wait_count = '0;
                    s.phase = PH_COLUMN;
                end
            end
            PH_COLUMN: begin
                if (!col_high) begin
                    s.phase     = PH_PROBE;
                    s.row_index = '0;
                    o.row_drive = LEVEL_W'(1);
                end else begin
                    s.row_index = '0;
                    if (cur.column_index == LAST_COL) begin
                        s.column_index = '0;
                        s.phase = (cur.held_count == '0) ? PH_IDLE : PH_POLL;
                    end else begin
                        s.column_index = cur.column_index + 1'b1;
                    end
                end
            end
            PH_PROBE: begin
                if (col_high && !cur.held_mask[pos]) begin
                    s.held_mask[pos] = 1'b1;
                    s.held_count     = cur.held_count + 1'b1;
                    o.event_valid    = 1'b1;
                    o.key_row        = cur.row_index;
                    o.key_column     = cur.column_index;
                end
                if (cur.row_index != LAST_ROW) begin
                    s.row_index = cur.row_index + 1'b1;
                    o.row_drive = LEVEL_W'(1) << s.row_index;
                end else begin
                    s.row_index = '0;
                    if (cur.column_index == LAST_COL) begin
                        s.column_index = '0;
                        s.phase = (s.held_count == '0) ? PH_IDLE : PH_POLL;
                    end else begin
                        s.column_index = cur.column_index + 1'b1;
                        s.phase        = PH_COLUMN;
                    end
                end
            end
            PH_POLL: begin
                if (cur.held_mask[pos] && col_high) begin
                    s.held_mask[pos] = 1'b0;
                    if (cur.held_count != '0) begin
                        s.held_count = cur.held_count - 1'b1;
                    end
                    o.event_valid   = 1'b1;
                    o.event_release = 1'b1;
                    o.key_row       = cur.row_index;
                    o.key_column    = cur.column_index;
                    s.row_index     = '0;
                    if (s.held_count == '0) begin
                        s.held_mask    = '0;
                        s.phase        = PH_IDLE;
                        s.column_index = '0;
                    end else if (cur.column_index == LAST_COL) begin
                        s.column_index = '0;
                    end else begin
                        s.column_index = cur.column_index + 1'b1;
                    end
                end else if (cur.row_index != LAST_ROW) begin
                    s.row_index = cur.row_index + 1'b1;
                end else begin
                    s.row_index = '0;
                    if (cur.column_index == LAST_COL) begin
                        s.column_index = '0;
                    end else begin
                        s.column_index = cur.column_index + 1'b1;
                    end
                end
            end
            default: begin
                s = STATE_RESET;
            end
        endcase

        o.busy_res = (s.phase != PH_IDLE);
        nxt = s;
        res = o;
    end

endmodule
`default_nettype wire

// ===== rtl/keypad_matrix_scanner_top.sv =====
// Keypad matrix scanner top level: input register, scan state, result register.
// Depends on kms_pkg, kms_apb_regs and kms_step.
//
// Usage:
//   s_* carries one transaction per tick of the key matrix: the sampled column
//   levels in s_tdata[2:0]. m_* returns exactly one result per input:
//   row lines to drive, the press/release event and the busy flag.
//   debounce_ticks (APB byte address 0) must be written only while idle; the block does not check.
// Path: an accepted input is held in the input register; its result is registered
//   into the result register once that is free and shows on m_* from then on.
// Throughput: one transaction per cycle while the result is not stalled; the scan
//   state updates in a single combinational step between the input and result registers.
// Reset (aresetn low, synchronous): both registers empty, scan state idle,
//   debounce_ticks back to 2.
// Stall: while m_tready is low the result holds; if the input register is empty,
//   one more input is taken into it, then s_tready drops until the result drains.
`default_nettype none
module keypad_matrix_scanner_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // [2:0] column_levels
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [2:0] row_drive, [4:3] key_row, [6:5] key_column, [7] busy_res
    output logic      [7:0]  m_tdata,
    // [0] event_valid, [1] event_release
    output logic      [1:0]  m_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import kms_pkg::*;

    logic [WAIT_W-1:0]  debounce_ticks;
    logic               in_valid_reg;
    logic [LEVEL_W-1:0] in_levels_reg;
    logic               out_valid_reg;
    scan_result_t       out_reg;
    scan_state_t        state_reg;
    scan_state_t        state_next;
    scan_result_t       res_next;
    logic               out_free;
    logic               advance;

    kms_apb_regs u_regs (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .debounce_ticks (debounce_ticks)
    );

    kms_step u_step (
        .cur            (state_reg),
        .levels         (in_levels_reg),
        .debounce_ticks (debounce_ticks),
        .nxt            (state_next),
        .res            (res_next)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_levels_reg <= s_tdata[LEVEL_W-1:0];
        end
        if (advance) begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.busy_res, out_reg.key_column, out_reg.key_row,
                       out_reg.row_drive};
    assign m_tuser  = {out_reg.event_release, out_reg.event_valid};

endmodule
`default_nettype wire

// ===== rtl/kms_checker.sv =====
// Keypad matrix scanner port checker and its bind to the top level.
// Sees only the top-level ports; no package dependency.
`default_nettype none
module kms_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic [7:0] m_tdata,
    input wire logic [1:0] m_tuser,
    input wire logic       m_tvalid,
    input wire logic       m_tready
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_no_event_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> !m_tuser[1] && m_tdata[6:3] == 4'd0)
        else $error("key fields set without an event");

    a_press_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] && !m_tuser[1] |-> m_tdata[7]
            && m_tdata[4:3] != 2'd3 && m_tdata[6:5] != 2'd3)
        else $error("press event with bad key or not busy");

    a_row_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0(m_tdata[2:0]) && (m_tdata[2:0] == 3'd0 || m_tdata[7]))
        else $error("row drive not one-hot or driven while idle");

endmodule

bind keypad_matrix_scanner_top kms_checker u_kms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for keypad_matrix_scanner_top: drives column samples, some from an emulated key
// matrix, checks every m_ transaction against a local scanner model. Depends on kms_pkg
// and the RTL below keypad_matrix_scanner_top.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kms_pkg::*;

    localparam logic [2:0] DEBOUNCE_ADDR = 3'd0;

    typedef struct {
        bit         is_raw;
        logic [8:0] bits;
    } pad_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [7:0]  s_tdata = '0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    wire  [7:0]  m_tdata;
    wire  [1:0]  m_tuser;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;

    keypad_matrix_scanner_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // scanner model state
    logic [WAIT_W-1:0] bounce_ticks = DEBOUNCE_RESET;
    phase_t            scan_phase = PH_IDLE;
    logic [WAIT_W-1:0] settle_left = '0;
    logic [IDX_W-1:0]  col_at = '0;
    logic [IDX_W-1:0]  row_at = '0;
    logic [KEYS-1:0]   held_keys = '0;
    logic [HCNT_W-1:0] held_total = '0;

    pad_item_t    pad_queue[$];
    scan_result_t expected_q[$];
    logic [2:0]   rows_now = '0;
    bit           levels_taken = 1'b0;
    bit           calm = 1'b0;
    int           send_gap = 0;
    int           hold_gap = 0;
    int           mismatches = 0;
    int           samples_in = 0;
    int           results_checked = 0;
    int           presses_seen = 0;
    int           releases_seen = 0;
    int           mid_ticks = 0;
    pad_item_t    next_item;
    scan_result_t predicted;
    scan_result_t got;
    scan_result_t want;

    function automatic void begin_scan();
        scan_phase = PH_COLUMN;
        col_at = '0;
        row_at = '0;
        held_keys = '0;
        held_total = '0;
    endfunction

    function automatic void advance_scan_column();
        row_at = '0;
        if (col_at == LAST_COL) begin
            col_at = '0;
            scan_phase = (held_total == 0) ? PH_IDLE : PH_POLL;
        end else begin
            col_at = col_at + 1'b1;
            scan_phase = PH_COLUMN;
        end
    endfunction

    function automatic void advance_poll_column();
        row_at = '0;
        col_at = (col_at == LAST_COL) ? '0 : col_at + 1'b1;
    endfunction

    function automatic scan_result_t scan_tick(input logic [2:0] levels);
        scan_result_t res;
        logic         col_hi;
        int           pos;
        res = '0;
        col_hi = (col_at < COLS) ? levels[col_at] : 1'b0;
        pos = row_at * COLS + col_at;
        case (scan_phase)
            PH_IDLE: begin
                if (levels != 3'b111) begin
                    if (bounce_ticks == 0) begin
                        begin_scan();
                    end else begin
                        settle_left = bounce_ticks;
                        scan_phase = PH_DEBOUNCE;
                    end
                end
            end
            PH_DEBOUNCE: begin
                if (settle_left > 0)
                    settle_left = settle_left - 1'b1;
                if (settle_left == 0)
                    begin_scan();
            end
            PH_COLUMN: begin
                if (!col_hi) begin
                    scan_phase = PH_PROBE;
                    row_at = '0;
                    res.row_drive = 3'b001;
                end else begin
                    advance_scan_column();
                end
            end
            PH_PROBE: begin
                if (col_hi && !held_keys[pos]) begin
                    held_keys[pos] = 1'b1;
                    held_total = held_total + 1'b1;
                    res.event_valid = 1'b1;
                    res.key_row = row_at;
                    res.key_column = col_at;
                end
                if (row_at < LAST_ROW) begin
                    row_at = row_at + 1'b1;
                    res.row_drive = 3'b001 << row_at;
                end else begin
                    advance_scan_column();
                end
            end
            PH_POLL: begin
                if (held_keys[pos] && col_hi) begin
                    held_keys[pos] = 1'b0;
                    if (held_total > 0)
                        held_total = held_total - 1'b1;
                    res.event_valid = 1'b1;
                    res.event_release = 1'b1;
                    res.key_row = row_at;
                    res.key_column = col_at;
                    if (held_total == 0) begin
                        held_keys = '0;
                        scan_phase = PH_IDLE;
                        col_at = '0;
                        row_at = '0;
                    end else begin
                        advance_poll_column();
                    end
                end else if (row_at < LAST_ROW) begin
                    row_at = row_at + 1'b1;
                end else begin
                    advance_poll_column();
                end
            end
            default: begin
                scan_phase = PH_IDLE;
                settle_left = '0;
                col_at = '0;
                row_at = '0;
                held_keys = '0;
                held_total = '0;
            end
        endcase
        res.busy_res = (scan_phase != PH_IDLE);
        return res;
    endfunction

    // column lines of a physical matrix: a pressed key on an undriven row pulls its column low
    function automatic logic [2:0] pad_levels(input logic [8:0] keys, input logic [2:0] rows);
        logic [2:0] lvl;
        lvl = 3'b111;
        for (int c = 0; c < COLS; c++)
            for (int r = 0; r < ROWS; r++)
                if (keys[r * COLS + c] && !rows[r])
                    lvl[c] = 1'b0;
        return lvl;
    endfunction

    function automatic int pick_gap();
        int p;
        if (calm)
            return 0;
        p = $urandom_range(99);
        if (p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic string show(input scan_result_t r);
        return $sformatf("rows=%b ev=%b rel=%b key=(%0d,%0d) busy=%b", r.row_drive,
                         r.event_valid, r.event_release, r.key_row, r.key_column, r.busy_res);
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // input driver
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || levels_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pad_queue.size() > 0) begin
                next_item = pad_queue.pop_front();
                s_tdata <= {5'd0, next_item.is_raw ? next_item.bits[2:0]
                                                   : pad_levels(next_item.bits, rows_now)};
                s_tvalid <= 1'b1;
                send_gap = pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        levels_taken = 1'b0;
    end

    // result backpressure
    always @(negedge aclk) begin
        if (hold_gap > 0) begin
            hold_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            hold_gap = pick_gap();
        end
    end

    // monitor: predict on input transactions, check result transactions
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predicted = scan_tick(s_tdata[2:0]);
                rows_now = predicted.row_drive;
                expected_q.push_back(predicted);
                levels_taken = 1'b1;
                samples_in++;
                if (predicted.event_valid) begin
                    if (predicted.event_release)
                        releases_seen++;
                    else
                        presses_seen++;
                end
            end
            if (m_tvalid && m_tready) begin
                got.row_drive = m_tdata[2:0];
                got.key_row = m_tdata[4:3];
                got.key_column = m_tdata[6:5];
                got.busy_res = m_tdata[7];
                got.event_valid = m_tuser[0];
                got.event_release = m_tuser[1];
                if (expected_q.size() == 0) begin
                    note_mismatch({"unexpected result ", show(got)});
                end else begin
                    want = expected_q.pop_front();
                    if (got.row_drive !== want.row_drive ||
                        got.event_valid !== want.event_valid ||
                        got.event_release !== want.event_release ||
                        got.key_row !== want.key_row ||
                        got.key_column !== want.key_column ||
                        got.busy_res !== want.busy_res)
                        note_mismatch($sformatf("result %0d expected %s, got %s",
                                                results_checked, show(want), show(got)));
                end
                results_checked++;
            end
        end
    end

    task automatic add_item(input bit is_raw, input logic [8:0] bits, input int reps);
        pad_item_t it;
        it.is_raw = is_raw;
        it.bits = bits;
        repeat (reps) pad_queue.push_back(it);
    endtask

    // mostly key presses held past the debounce, with partial releases; some raw noise
    task automatic queue_random(input int count);
        int         added;
        int         n;
        logic [8:0] keys;
        added = 0;
        while (added < count) begin
            if ($urandom_range(99) < 20) begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    add_item(1'b1, 9'($urandom_range(7)), 1);
                added += n;
            end else begin
                keys = '0;
                if ($urandom_range(99) < 70)
                    repeat ($urandom_range(1, 3)) keys[$urandom_range(KEYS - 1)] = 1'b1;
                else
                    keys = 9'($urandom_range(1, 511));
                n = bounce_ticks + $urandom_range(6, 30);
                add_item(1'b0, keys, n);
                added += n;
                if ($urandom_range(1)) begin
                    n = $urandom_range(3, 15);
                    add_item(1'b0, keys & 9'($urandom), n);
                    added += n;
                end
                n = $urandom_range(4, 20);
                add_item(1'b0, '0, n);
                added += n;
            end
        end
    endtask

    task automatic settle_traffic();
        while (pad_queue.size() != 0 || s_tvalid || expected_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_debounce(input logic [7:0] ticks);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= DEBOUNCE_ADDR;
        pwdata <= {24'd0, ticks};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        bounce_ticks = ticks;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        add_item(1'b1, 9'd7, 1);
        for (int v = 0; v < 7; v++)
            add_item(1'b1, 9'(v), 1);
        add_item(1'b1, 9'd7, 3);
        add_item(1'b0, 9'h100, 9);
        add_item(1'b0, 9'h000, 5);
        settle_traffic();

        set_debounce(8'd0);
        queue_random(30);
        settle_traffic();

        // one key held through the longest debounce, then released
        calm = 1'b1;
        set_debounce(8'd255);
        add_item(1'b0, 9'h010, 264);
        add_item(1'b0, 9'h000, 12);
        settle_traffic();
        calm = 1'b0;

        set_debounce(8'd1);
        queue_random(15);
        settle_traffic();

        mid_ticks = $urandom_range(3, 12);
        set_debounce(8'(mid_ticks));
        queue_random(15);
        settle_traffic();

        set_debounce(DEBOUNCE_RESET);
        queue_random(10);
        settle_traffic();
        repeat (4) @(posedge aclk);

        if (expected_q.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", expected_q.size()));
        $display("Fed %0d column samples under debounce 2, 0, 255, 1, %0d and 2 ticks.",
                 samples_in, mid_ticks);
        $display("Checked %0d results carrying %0d press and %0d release events.",
                 results_checked, presses_seen, releases_seen);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #500000;
        $display("TIMEOUT after %0t", $realtime);
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/kms_pkg.sv
rtl/kms_apb_regs.sv
rtl/kms_step.sv
rtl/keypad_matrix_scanner_top.sv
rtl/kms_checker.sv
tb/sv/tb.sv
